>>> sv/slfd_pkg.sv
`timescale 1ns / 1ps
package slfd_pkg;
   localparam int QueueDepth = 2;
   localparam logic [10:0] QLfm = 11'd410;
   localparam logic [10:0] QP90 = 11'd205;
   localparam logic [10:0] QP45 = 11'd922;
   localparam logic [10:0] QP00 = 11'd1229;
   localparam logic [12:0] GroundWhite = 13'd900;
   localparam logic [11:0] SimOffset = 12'd300;

   typedef enum logic [1:0] {
      SIDE_NONE = 2'd0, SIDE_LEFT = 2'd1, SIDE_RIGHT = 2'd2
   } side_type;

   typedef enum logic [1:0] {
      PH_STANDBY = 2'd0, PH_LOOKING = 2'd1, PH_DETECTED = 2'd2, PH_ONLINE = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      REG_FOLLOW_SPEED = 3'd0, REG_OBST_THR = 3'd1, REG_AVOID_SPEED = 3'd2,
      REG_AVOID_LIMIT = 3'd3, REG_LEAVE_THR = 3'd4, REG_CIRCLE_SPEED = 3'd5,
      REG_ENTER_SPEED = 3'd6, REG_ENTER_THR = 3'd7
   } reg_type;

   typedef struct packed {
      logic [9:0]  follow_speed;
      logic [11:0] obstacle_threshold;
      logic [9:0]  avoid_speed;
      logic [9:0]  avoid_delta_limit;
      logic [9:0]  leave_threshold;
      logic [9:0]  circle_speed;
      logic [9:0]  enter_speed;
      logic [9:0]  enter_threshold;
   } cfg_type;

   // classified tick: offset-corrected readings plus mode-change flag
   typedef struct packed {
      logic [7:0][11:0] prox;
      logic [9:0]       gl;
      logic [9:0]       gc;
      logic [9:0]       gr;
      logic             mode_change;
   } tick_type;

   function automatic logic [11:0] real_offset(input logic [2:0] i);
      logic [11:0] r;
      case (i)
         3'd0: r = 12'd480;
         3'd1: r = 12'd170;
         3'd2: r = 12'd320;
         3'd3: r = 12'd500;
         3'd4: r = 12'd600;
         3'd5: r = 12'd680;
         3'd6: r = 12'd210;
         default: r = 12'd640;
      endcase
      return r;
   endfunction
endpackage

>>> sv/slfd_front.sv
`timescale 1ns / 1ps
module slfd_front import slfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0][11:0]  prox,
   input  logic [9:0]        gl,
   input  logic [9:0]        gc,
   input  logic [9:0]        gr,
   input  logic [1:0]        mode,
   output tick_type          tick
);
   logic [1:0] last_mode_ff, last_mode_in;
   logic       loaded_ff, loaded_in;
   logic       chg;

   always_comb begin
      logic [11:0] off;
      chg = (mode != last_mode_ff);
      last_mode_in = take ? mode : last_mode_ff;
      loaded_in = loaded_ff | (take & chg);
      tick.gl = gl;
      tick.gc = gc;
      tick.gr = gr;
      tick.mode_change = chg;
      for (int i = 0; i < 8; i++) begin
         off = '0;
         if (loaded_ff || chg) off = (mode == 2'd0) ? SimOffset : real_offset(3'(i));
         tick.prox[i] = (prox[i] > off) ? prox[i] - off : 12'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mode_ff <= 2'd1;
         loaded_ff <= 1'b0;
      end else begin
         last_mode_ff <= last_mode_in;
         loaded_ff <= loaded_in;
      end
   end
endmodule

>>> sv/slfd_queue.sv
`timescale 1ns / 1ps
module slfd_queue import slfd_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  tick_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output tick_type out_data
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   tick_type mem [Depth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic wr, rd;

   assign in_ready = (cnt_ff != (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_data = mem[rp_ff];
   assign wr = in_valid & in_ready;
   assign rd = out_valid & out_ready;

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (wr) wp_in = (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
      if (rd) rp_in = (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (wr) mem[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

>>> sv/slfd_back.sv
`timescale 1ns / 1ps
module slfd_back import slfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  tick_type          tick,
   output logic              out_valid,
   input  logic              out_ready,
   output logic signed [10:0] left_speed,
   output logic signed [10:0] right_speed,
   output logic              avoiding,
   output logic              entering,
   output logic [1:0]        enter_phase,
   output logic [1:0]        obstacle_side
);
   logic       av_act_ff, av_act_in, clr_ff, clr_in, lv_act_ff, lv_act_in;
   logic       inh_ff, inh_in, circ_ff, circ_in, rst_ff, rst_in;
   logic       en_act_ff, en_act_in, pfb_ff, pfb_in;
   side_type   side_ff, side_in, lps_ff, lps_in;
   phase_type  ph_ff, ph_in;
   logic       ov_ff;
   logic signed [10:0] ls_ff, rs_ff, ls_in, rs_in;
   logic       take;

   assign in_ready = !ov_ff || out_ready;
   assign take = in_valid && in_ready;

   function automatic logic signed [10:0] sat(input logic signed [14:0] v);
      if (v > 15'sd1023) return 11'sd1023;
      if (v < -15'sd1024) return -11'sd1024;
      return v[10:0];
   endfunction

   always_comb begin
      logic signed [14:0] sl, sr, ol, orr, cl, cr, el, er, d, lim, k, base;
      logic signed [11:0] diff;
      logic [21:0] mag;
      logic [24:0] wsum;
      logic [11:0] mx, p0, p1, p6, p7;
      logic [12:0] actr, actl, gn13;
      logic [10:0] avg;
      logic [9:0]  gn, gf, tgt;
      logic        left, cur;
      logic        lva, cir, ena, pfb, inh, rst, clr, ava;
      side_type    sd, lps;
      phase_type   ph;

      lva = lv_act_ff; lps = lps_ff; cir = circ_ff; ena = en_act_ff; ph = ph_ff;
      clr = clr_ff; ava = av_act_ff; sd = side_ff; pfb = pfb_ff; inh = inh_ff;
      rst = rst_ff;
      if (tick.mode_change) begin
         clr = 1'b1; lva = 1'b0; lps = SIDE_NONE; cir = 1'b0; ena = 1'b0;
         ph = PH_STANDBY;
      end
      p0 = tick.prox[0]; p1 = tick.prox[1]; p6 = tick.prox[6]; p7 = tick.prox[7];
      // line following
      diff = $signed({2'b0, tick.gr}) - $signed({2'b0, tick.gl});
      mag = (diff < 0) ? 22'(-diff) * 22'(QLfm) : 22'(diff) * 22'(QLfm);
      d = (diff < 0) ? -$signed(15'(mag >> 10)) : $signed(15'(mag >> 10));
      sl = $signed(15'(cfg.follow_speed)) - d;
      sr = $signed(15'(cfg.follow_speed)) + d;
      // avoidance
      if (clr) begin ava = 1'b0; sd = SIDE_NONE; end
      clr = 1'b0;
      mx = p0;
      if (p1 > mx) mx = p1;
      if (p6 > mx) mx = p6;
      if (p7 > mx) mx = p7;
      if (mx > cfg.obstacle_threshold) ava = 1'b1;
      actr = 13'(p0) + 13'(p1);
      actl = 13'(p6) + 13'(p7);
      if (ava && sd == SIDE_NONE) sd = (actr > actl) ? SIDE_RIGHT : SIDE_LEFT;
      ol = $signed(15'(cfg.avoid_speed));
      orr = ol;
      if (sd == SIDE_LEFT)
         wsum = 25'(tick.prox[5]) * 25'(QP90) + 25'(p6) * 25'(QP45) + 25'(p7) * 25'(QP00);
      else
         wsum = 25'(tick.prox[2]) * 25'(QP90) + 25'(p1) * 25'(QP45) + 25'(p0) * 25'(QP00);
      lim = $signed(15'(cfg.avoid_delta_limit));
      d = (wsum[24:10] > 15'(cfg.avoid_delta_limit)) ? lim : $signed(wsum[24:10]);
      if (sd == SIDE_LEFT) d = -d;
      if (ava) begin ol = ol - d; orr = orr + d; end
      // line leaving
      if (!lva && sd != SIDE_NONE && lps == SIDE_NONE) lva = 1'b1;
      lps = sd;
      tgt = (sd == SIDE_LEFT) ? tick.gl : tick.gr;
      avg = 11'((12'(tick.gc) + 12'(tgt)) >> 1);
      if (lva) begin
         if (avg > 11'(cfg.leave_threshold)) begin
            lva = 1'b0; inh = 1'b0; rst = 1'b1;
         end else inh = 1'b1;
      end
      // obstacle following
      if (sd != SIDE_NONE) begin
         cir = 1'b1;
         cl = (sd == SIDE_LEFT) ? -$signed(15'(cfg.circle_speed))
                                : $signed(15'(cfg.circle_speed));
         cr = -cl;
      end else begin
         cir = 1'b0; cl = '0; cr = '0;
      end
      if (inh) begin cl = '0; cr = '0; end
      if (ava || cir) begin sl = ol + cl; sr = orr + cr; end
      // line entering
      left = (sd == SIDE_LEFT);
      gn = left ? tick.gr : tick.gl;
      gf = left ? tick.gl : tick.gr;
      base = $signed(15'(cfg.enter_speed));
      if (rst) ph = PH_LOOKING;
      rst = 1'b0;
      el = base; er = base;
      cur = (gf < cfg.enter_threshold);
      gn13 = GroundWhite - 13'(gn);
      k = gn13[12] ? -$signed(15'((13'(-gn13)) >> 1)) : $signed(15'(gn13 >> 1));
      case (ph)
         PH_STANDBY: ena = 1'b0;
         PH_LOOKING: begin
            if (gn < cfg.enter_threshold) begin
               ena = 1'b1; ph = PH_DETECTED; pfb = cur;
            end
         end
         PH_DETECTED: begin
            if (pfb && !cur) begin
               ph = PH_ONLINE; el = '0; er = '0;
            end else begin
               pfb = cur;
               if (left) begin el = base + k; er = base - k; end
               else begin er = base + k; el = base - k; end
            end
         end
         default: begin
            clr = 1'b1; sd = SIDE_NONE; ena = 1'b0; ph = PH_STANDBY;
         end
      endcase
      if (ena) begin sl = el; sr = er; end

      ls_in = sat(sl); rs_in = sat(sr);
      av_act_in = ava; clr_in = clr; lv_act_in = lva; inh_in = inh; circ_in = cir;
      rst_in = rst; en_act_in = ena; pfb_in = pfb; side_in = sd; lps_in = lps;
      ph_in = ph;
   end

   assign out_valid = ov_ff;
   assign left_speed = ls_ff;
   assign right_speed = rs_ff;
   assign avoiding = av_act_ff;
   assign entering = en_act_ff;
   assign enter_phase = ph_ff;
   assign obstacle_side = side_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         ls_ff <= ls_in;
         rs_ff <= rs_in;
      end
      if (reset) begin
         ov_ff <= 1'b0; av_act_ff <= 1'b0; clr_ff <= 1'b0; lv_act_ff <= 1'b0;
         inh_ff <= 1'b0; circ_ff <= 1'b0; rst_ff <= 1'b0; en_act_ff <= 1'b0;
         pfb_ff <= 1'b0; side_ff <= SIDE_NONE; lps_ff <= SIDE_NONE;
         ph_ff <= PH_STANDBY;
      end else begin
         if (take) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
         if (take) begin
            av_act_ff <= av_act_in; clr_ff <= clr_in; lv_act_ff <= lv_act_in;
            inh_ff <= inh_in; circ_ff <= circ_in; rst_ff <= rst_in;
            en_act_ff <= en_act_in; pfb_ff <= pfb_in; side_ff <= side_in;
            lps_ff <= lps_in; ph_ff <= ph_in;
         end
      end
   end
endmodule

>>> sv/subsumption_line_follow_drive.sv
`timescale 1ns / 1ps
// A request passes the front logic into the queue registers, then the back stage's
// output register, before rsp valid. Throughput: one tick per cycle while rsp_ready
// is high, limited by the behavior update in the back stage that each tick depends on.
// Reset (synchronous, active high) empties the queue, restores behavior state and
// loads the register defaults.
module subsumption_line_follow_drive import slfd_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_prox_0,
   input  logic [11:0] req_prox_1,
   input  logic [11:0] req_prox_2,
   input  logic [11:0] req_prox_3,
   input  logic [11:0] req_prox_4,
   input  logic [11:0] req_prox_5,
   input  logic [11:0] req_prox_6,
   input  logic [11:0] req_prox_7,
   input  logic [9:0]  req_ground_left,
   input  logic [9:0]  req_ground_center,
   input  logic [9:0]  req_ground_right,
   input  logic [1:0]  req_run_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [10:0] rsp_left_speed,
   output logic signed [10:0] rsp_right_speed,
   output logic        rsp_avoiding,
   output logic        rsp_entering,
   output logic [1:0]  rsp_enter_phase,
   output logic [1:0]  rsp_obstacle_side,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   cfg_type  cfg_ff, cfg_in;
   tick_type fr_tick, q_tick;
   logic     q_valid, q_ready, take;
   reg_type  ra;

   assign pready = 1'b1;
   assign ra = reg_type'(paddr[4:2]);
   assign take = req_valid & req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
         case (ra)
            REG_FOLLOW_SPEED: cfg_in.follow_speed = pwdata[9:0];
            REG_OBST_THR:     cfg_in.obstacle_threshold = pwdata[11:0];
            REG_AVOID_SPEED:  cfg_in.avoid_speed = pwdata[9:0];
            REG_AVOID_LIMIT:  cfg_in.avoid_delta_limit = pwdata[9:0];
            REG_LEAVE_THR:    cfg_in.leave_threshold = pwdata[9:0];
            REG_CIRCLE_SPEED: cfg_in.circle_speed = pwdata[9:0];
            REG_ENTER_SPEED:  cfg_in.enter_speed = pwdata[9:0];
            default:          cfg_in.enter_threshold = pwdata[9:0];
         endcase
      end
      case (ra)
         REG_FOLLOW_SPEED: prdata = 32'(cfg_ff.follow_speed);
         REG_OBST_THR:     prdata = 32'(cfg_ff.obstacle_threshold);
         REG_AVOID_SPEED:  prdata = 32'(cfg_ff.avoid_speed);
         REG_AVOID_LIMIT:  prdata = 32'(cfg_ff.avoid_delta_limit);
         REG_LEAVE_THR:    prdata = 32'(cfg_ff.leave_threshold);
         REG_CIRCLE_SPEED: prdata = 32'(cfg_ff.circle_speed);
         REG_ENTER_SPEED:  prdata = 32'(cfg_ff.enter_speed);
         default:          prdata = 32'(cfg_ff.enter_threshold);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.follow_speed <= 10'd200;
         cfg_ff.obstacle_threshold <= 12'd100;
         cfg_ff.avoid_speed <= 10'd150;
         cfg_ff.avoid_delta_limit <= 10'd600;
         cfg_ff.leave_threshold <= 10'd550;
         cfg_ff.circle_speed <= 10'd150;
         cfg_ff.enter_speed <= 10'd100;
         cfg_ff.enter_threshold <= 10'd500;
      end else cfg_ff <= cfg_in;
   end

   slfd_front u_front (
      .clock(clock), .reset(reset), .take(take),
      .prox({req_prox_7, req_prox_6, req_prox_5, req_prox_4,
             req_prox_3, req_prox_2, req_prox_1, req_prox_0}),
      .gl(req_ground_left), .gc(req_ground_center), .gr(req_ground_right),
      .mode(req_run_mode), .tick(fr_tick)
   );

   slfd_queue #(.Depth(Depth)) u_queue (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_data(fr_tick), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_tick)
   );

   slfd_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .in_valid(q_valid),
      .in_ready(q_ready), .tick(q_tick), .out_valid(rsp_valid), .out_ready(rsp_ready),
      .left_speed(rsp_left_speed), .right_speed(rsp_right_speed),
      .avoiding(rsp_avoiding), .entering(rsp_entering),
      .enter_phase(rsp_enter_phase), .obstacle_side(rsp_obstacle_side)
   );
endmodule
